// ----- rtl/bdvs_pkg.sv -----
// shared types and constants for the bounded distinct value set
// request codes and the command and status groups between controller and datapath
package bdvs_pkg;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_DEL   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic scan_en;
        logic shift_init;
        logic shift_en;
        logic commit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic scan_done;
        logic shift_done;
        logic del_hit;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/bounded_distinct_value_set.sv -----
// bounded distinct value set: a lookup waits on the one-entry-per-cycle scan of the
// single-read-port entry memory, which stops at the first match; a delete that hits shifts
// later entries through the same port before it answers. one request at a time; the next
// transfer in is taken in the cycle after the result is registered, even while it waits.
// synchronous active-low reset clears count and handshake state, not the entry memory
module bounded_distinct_value_set
    import bdvs_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_req_type,
    input  logic [VALUE_BITS-1:0] i_value,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_was_present,
    output logic [4:0]            o_entry_count,
    output logic                  o_overflow
);

    // command and status groups between sequencer and datapath
    t_cmd    w_cmd;
    t_status w_status;

    // sequencer: idle, scan, shift on a delete hit, then hand the result over
    bdvs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // entries live in insertion order below the count; scan compares one per cycle
    bdvs_datapath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_was_present (o_was_present),
        .o_entry_count (o_entry_count),
        .o_overflow    (o_overflow)
    );

endmodule

// ----- rtl/bdvs_ctrl.sv -----
// sequencing state machine for the bounded distinct value set
// depends on bdvs_pkg for the command and status structs
module bdvs_ctrl
    import bdvs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    if (i_status.del_hit) begin
                        o_cmd.shift_init = 1'b1;
                        n_state          = ST_SHIFT;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end else begin
                    o_cmd.scan_en = 1'b1;
                end
            end
            ST_SHIFT: begin
                if (i_status.shift_done) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.shift_en = 1'b1;
                end
            end
            ST_FINISH: begin
                // wait until the result register can take the result
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != ST_IDLE);
        end
    end

    assign o_in_stall = r_in_stall;

endmodule

// ----- rtl/bdvs_datapath.sv -----
// entry memory, count, scan and shift pointers and result register
// depends on bdvs_pkg for request codes and the command and status structs
module bdvs_datapath
    import bdvs_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [1:0]            i_req_type,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic                  o_was_present,
    output logic [4:0]            o_entry_count,
    output logic                  o_overflow
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    logic [VALUE_BITS-1:0] r_mem [CAPACITY];
    logic [VALUE_BITS-1:0] r_rdata;

    logic [1:0]            r_op;
    logic [VALUE_BITS-1:0] r_val;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         r_wptr;
    logic                  r_pv;
    logic                  r_hit;

    logic                  r_o_valid;
    logic                  r_o_present;
    logic [4:0]            r_o_count;
    logic                  r_o_ovf;

    logic                  w_more;
    logic                  w_rd_en;
    logic                  w_match;
    logic                  w_sh_wr;
    logic                  w_add_wr;
    logic                  w_is_add;
    logic                  w_is_del;
    logic                  w_ovf;
    logic                  w_out_free;
    logic [CW+4:0]         w_cnt_ext;

    assign w_more   = (r_idx < r_cnt);
    assign w_rd_en  = (i_cmd.scan_en && !r_hit && w_more) || (i_cmd.shift_en && w_more);
    assign w_match  = i_cmd.scan_en && r_pv && !r_hit && (r_rdata == r_val);
    assign w_sh_wr  = i_cmd.shift_en && r_pv;
    assign w_is_add = (r_op == REQ_ADD);
    assign w_is_del = (r_op == REQ_DEL);
    assign w_ovf    = w_is_add && !r_hit && (r_cnt >= CAP_C);
    assign w_add_wr = i_cmd.commit && w_is_add && !r_hit && (r_cnt < CAP_C);
    assign w_out_free = !r_o_valid || !i_out_stall;

    always_comb begin
        n_cnt = r_cnt;
        if (w_add_wr) begin
            n_cnt = r_cnt + ONE_C;
        end else if (w_is_del && r_hit) begin
            n_cnt = r_cnt - ONE_C;
        end
    end

    assign w_cnt_ext = {5'b0, n_cnt};

    // single write port shared by the delete shift and the add append
    always_ff @(posedge i_clk) begin
        if (w_sh_wr) begin
            r_mem[r_wptr[IW-1:0]] <= r_rdata;
        end else if (w_add_wr) begin
            r_mem[r_cnt[IW-1:0]] <= r_val;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[r_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_req_type;
            r_val <= i_value;
        end
        // slot of the match, then the shift write pointer
        if (w_match) begin
            r_wptr <= r_idx - ONE_C;
        end else if (w_sh_wr) begin
            r_wptr <= r_wptr + ONE_C;
        end
        if (i_cmd.accept) begin
            r_idx <= '0;
        end else if (i_cmd.shift_init) begin
            r_idx <= r_wptr + ONE_C;
        end else if (w_rd_en) begin
            r_idx <= r_idx + ONE_C;
        end
        if (i_cmd.commit) begin
            r_o_present <= r_hit;
            r_o_count   <= w_cnt_ext[4:0];
            r_o_ovf     <= w_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_pv      <= 1'b0;
            r_hit     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_cnt <= n_cnt;
            end
            if (i_cmd.accept || i_cmd.shift_init) begin
                r_pv <= 1'b0;
            end else if (i_cmd.scan_en || i_cmd.shift_en) begin
                r_pv <= w_rd_en;
            end
            if (i_cmd.accept) begin
                r_hit <= 1'b0;
            end else if (w_match) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_status.scan_done  = r_hit || (!r_pv && !w_more);
    assign o_status.shift_done = !r_pv && !w_more;
    assign o_status.del_hit    = w_is_del && r_hit;
    assign o_status.out_free   = w_out_free;

    assign o_out_valid   = r_o_valid;
    assign o_was_present = r_o_present;
    assign o_entry_count = r_o_count;
    assign o_overflow    = r_o_ovf;

endmodule

// ----- verif/tb_bounded_distinct_value_set.sv -----
// testbench for bounded_distinct_value_set: add, delete and query requests checked against
// a behavioral copy of the value table; depends on bdvs_pkg and the rtl top level only
module tb_bounded_distinct_value_set;
    import bdvs_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int VAL_W       = 8;
    // code 2'd3 has no name in the package; the block treats it as a query
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int IDLE_PCT     = 28;
    localparam int HOLD_CYCLES  = 300;
    // long enough for a delete that hits on a full table to answer
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic       was_present;
        logic [4:0] entry_count;
        logic       overflow;
    } set_result_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [1:0]       i_req_type = REQ_QUERY;
    logic [VAL_W-1:0] i_value = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic             o_was_present;
    logic [4:0]       o_entry_count;
    logic             o_overflow;

    // behavioral copy of the stored values, in insertion order
    logic [VAL_W-1:0] member_vals [TABLE_DEPTH];
    int               member_cnt = 0;
    set_result_t      pending_results [$];

    // shared between the stimulus and the receiver process
    logic idle_on = 1'b1;
    logic hold_req = 1'b0;
    int   hold_left = 0;

    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_hits = 0;
    int n_overflow = 0;
    int n_in_stalled = 0;
    int cycle_count = 0;

    bounded_distinct_value_set #(
        .CAPACITY   (TABLE_DEPTH),
        .VALUE_BITS (VAL_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_was_present (o_was_present),
        .o_entry_count (o_entry_count),
        .o_overflow    (o_overflow)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // apply one request to the table copy and return what the block should report
    function automatic set_result_t apply_request(input logic [1:0] op,
                                                  input logic [VAL_W-1:0] v);
        set_result_t r;
        int slot;
        slot = member_cnt;
        // first match only; entries at or above the count are never looked at
        for (int i = 0; i < member_cnt; i++) begin
            if (slot == member_cnt && member_vals[i] == v)
                slot = i;
        end
        r.was_present = (slot < member_cnt);
        r.overflow    = 1'b0;
        case (op)
            REQ_ADD: begin
                if (!r.was_present) begin
                    if (member_cnt >= TABLE_DEPTH) begin
                        r.overflow = 1'b1;
                    end else begin
                        member_vals[member_cnt] = v;
                        member_cnt++;
                    end
                end
            end
            REQ_DEL: begin
                if (r.was_present) begin
                    // close the gap: later entries move down one place
                    for (int j = slot; j < member_cnt - 1; j++)
                        member_vals[j] = member_vals[j + 1];
                    member_cnt--;
                end
            end
            default: ;  // query and the unused code change nothing
        endcase
        r.entry_count = member_cnt[4:0];
        return r;
    endfunction

    // offer one request, with a random idle gap in front, and hold it until the transfer;
    // returns at the clock edge where the transfer happens, valid still high
    task automatic send_request(input logic [1:0] op, input logic [VAL_W-1:0] v);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= op;
        i_value    <= v;
        // stall is settled by the falling edge; the transfer is at the next rising edge
        @(negedge i_clk);
        while (o_in_stall) begin
            n_in_stalled++;
            @(negedge i_clk);
        end
        pending_results.push_back(apply_request(op, v));
        n_sent++;
        @(posedge i_clk);
    endtask

    // result side: random stall, or a long hold-off when the stimulus asks for one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left   <= 0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // result check: sampled at the falling edge ahead of the transfer edge
    always @(negedge i_clk) begin
        set_result_t exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: was_present %0b count %0d overflow %0b",
                         $time, o_was_present, o_entry_count, o_overflow);
            end else begin
                exp_r = pending_results.pop_front();
                n_checked++;
                if (exp_r.was_present)
                    n_hits++;
                if (exp_r.overflow)
                    n_overflow++;
                if (o_was_present !== exp_r.was_present) begin
                    errors++;
                    $display("%0t: was_present mismatch: expected %0b actual %0b",
                             $time, exp_r.was_present, o_was_present);
                end
                if (o_entry_count !== exp_r.entry_count) begin
                    errors++;
                    $display("%0t: entry_count mismatch: expected %0d actual %0d",
                             $time, exp_r.entry_count, o_entry_count);
                end
                if (o_overflow !== exp_r.overflow) begin
                    errors++;
                    $display("%0t: overflow mismatch: expected %0b actual %0b",
                             $time, exp_r.overflow, o_overflow);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // empty table: a lookup and a delete that miss, duplicate add, unused code, values 0 and 255
    task automatic test_empty_table();
        send_request(REQ_QUERY, 8'h00);
        send_request(REQ_DEL, 8'h00);
        send_request(REQ_ADD, 8'h00);
        send_request(REQ_ADD, 8'h00);
        send_request(REQ_ADD, 8'hFF);
        send_request(REQ_UNUSED, 8'hFF);
    endtask

    // fill to capacity, reject on full, duplicate on full, then delete middle, first, last
    task automatic test_full_table();
        for (int i = 1; i <= TABLE_DEPTH - 2; i++)
            send_request(REQ_ADD, VAL_W'(i * 17));
        send_request(REQ_ADD, 8'h5A);    // rejected, table full
        send_request(REQ_ADD, 8'h00);    // already present on a full table
        send_request(REQ_DEL, 8'h88);    // middle entry
        send_request(REQ_DEL, 8'h00);    // oldest entry
        send_request(REQ_DEL, 8'hEE);    // newest entry
        send_request(REQ_QUERY, 8'h88);
    endtask

    // random requests drawn mostly from a small pool so that hits and full tables are common
    task automatic test_random_mix(input int n_items, input int pool_size,
                                   input int add_pct, input int del_pct);
        logic [VAL_W-1:0] pool [64];
        int               roll;
        logic [1:0]       op;
        logic [VAL_W-1:0] v;
        foreach (pool[i])
            pool[i] = VAL_W'($urandom_range(255));
        repeat (n_items) begin
            roll = $urandom_range(99);
            if (roll < add_pct)
                op = REQ_ADD;
            else if (roll < add_pct + del_pct)
                op = REQ_DEL;
            else if (roll < 94)
                op = REQ_QUERY;
            else
                op = REQ_UNUSED;
            if ($urandom_range(9) == 0)
                v = VAL_W'($urandom_range(255));
            else
                v = pool[$urandom_range(pool_size - 1)];
            send_request(op, v);
        end
    endtask

    // result side holds off for a long time while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        hold_req = 1'b1;
        test_random_mix(14, 12, 50, 25);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_full_table();
        test_random_mix(150, 6, 40, 30);
        test_random_mix(200, 24, 55, 20);
        test_output_backpressure();
        // a long stretch with no idling on either side
        idle_on = 1'b0;
        test_random_mix(120, 20, 50, 25);
        idle_on = 1'b1;
        test_random_mix(120, 40, 35, 35);
        test_random_mix(60, 64, 45, 20);

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        // catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d requests, %0d results checked in %0d cycles",
                 n_sent, n_checked, cycle_count);
        $display("%0d hits, %0d rejected adds, %0d stalled offers, %0d errors",
                 n_hits, n_overflow, n_in_stalled, errors);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bdvs_pkg.sv
rtl/bdvs_ctrl.sv
rtl/bdvs_datapath.sv
rtl/bounded_distinct_value_set.sv
verif/tb_bounded_distinct_value_set.sv
